FILE: rtl/char_lcd_writer_over_expander_defines.svh
// Assertion macros used by the checker file of the LCD writer.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef CHAR_LCD_WRITER_OVER_EXPANDER_DEFINES_SVH
`define CHAR_LCD_WRITER_OVER_EXPANDER_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define LCDX_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A plain condition that must hold whenever the qualifier is high.
`define LCDX_ASSERT_WHEN(name, qual, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (qual) |-> (cond)) else $error(msg);

`endif

FILE: rtl/lcdx_pkg.sv
// ----------------------------------------------------------------------------
// lcdx_pkg
// Shared types and constants for the character LCD writer that drives the
// display through a 4-bit port expander.
// ----------------------------------------------------------------------------
package lcdx_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_MOVE  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_RAW   = 2'd3
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_COLUMNS   = 2'd0,
		REG_LINES     = 2'd1,
		REG_DEV_ADDR  = 2'd2,
		REG_BACKLIGHT = 2'd3
	} reg_index_t;

	// Geometry limits and defaults
	localparam int MAX_COLUMNS_DEF = 40;
	localparam int MAX_LINES_DEF   = 4;
	localparam int COLUMNS_RESET   = 16;
	localparam int LINES_RESET     = 2;
	localparam logic [6:0] DEV_ADDR_RESET  = 7'd39;
	localparam logic       BACKLIGHT_RESET = 1'b1;

	// Controller commands and codes
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;
	localparam logic [7:0] LINE1_OFFSET = 8'h40;
	localparam logic [7:0] NEWLINE_CODE = 8'h0a;
	localparam logic [7:0] SLOW_CMD_MAX = 8'h03;

	// Expander byte bit positions
	localparam int EXP_RS_BIT = 0;
	localparam int EXP_RW_BIT = 1;
	localparam int EXP_EN_BIT = 2;
	localparam int EXP_BL_BIT = 3;

endpackage

FILE: rtl/char_lcd_writer_over_expander.sv
// ----------------------------------------------------------------------------
// char_lcd_writer_over_expander
// Turns character, move, clear and raw-command items into the byte stream
// for a 4-bit port expander in front of a character LCD, tracking the cursor.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     mode, char_code, col, row
//   output    out_valid / out_ready   bus_address, expander_byte, long_wait, last
//   config    cfg_we (no wait)        cfg_index, cfg_data
//
// A printed character or a clear gives eight expander bytes; a new line, a move
// or a raw command gives four. One byte leaves per cycle through the output
// register unless out_ready stalls it, and the next item is taken in the
// cycle its last byte enters the output register. Reset restores the register
// defaults and puts the cursor at column 0, row 0. While out_ready is low a
// valid byte on the output holds and the byte sequencer waits.
module char_lcd_writer_over_expander #(
	parameter int MAX_COLUMNS = lcdx_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_LINES   = lcdx_pkg::MAX_LINES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// Item input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	input  logic [5:0] col,
	input  logic [1:0] row,
	// Expander byte output
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] bus_address,
	output logic [7:0] expander_byte,
	output logic       long_wait,
	output logic       last,
	// Configuration writes
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam logic [5:0] MaxCols  = 6'(MAX_COLUMNS);
	localparam logic [2:0] MaxLines = 3'(MAX_LINES);
	localparam logic [5:0] ColsRst  = 6'((lcdx_pkg::COLUMNS_RESET > MAX_COLUMNS) ?
		MAX_COLUMNS : lcdx_pkg::COLUMNS_RESET);
	localparam logic [2:0] LinesRst = 3'((lcdx_pkg::LINES_RESET > MAX_LINES) ?
		MAX_LINES : lcdx_pkg::LINES_RESET);

	// Configuration and cursor state
	logic [5:0] columns_q;
	logic [2:0] lines_q;
	logic [6:0] dev_addr_q;
	logic       backlight_q;
	logic [5:0] cursor_col_q;
	logic [1:0] cursor_row_q;
	logic       wrapped_q;

	// Job register: up to two controller bytes for the accepted item
	logic       busy_s1;
	logic [7:0] b0_s1;
	logic [7:0] b1_s1;
	logic       d0_s1;
	logic       len8_s1;
	logic [2:0] idx_s1;

	// Output register
	logic       out_valid_s2;
	logic [6:0] addr_s2;
	logic [7:0] byte_s2;
	logic       wait_s2;
	logic       last_s2;

	// Handshake and sequencing
	logic       advance;
	logic       idx_last;
	logic       in_fire;

	// Next-state values for the accepted item
	logic       is_newline;
	logic [6:0] c_step;
	logic       do_wrap;
	logic [6:0] c_wrapped;
	logic [2:0] r_step;
	logic [2:0] r_final;
	logic       wrapped_next;
	logic [5:0] pos_col;
	logic [1:0] pos_row;
	logic [8:0] pos_sum;
	logic [7:0] pos_cmd;
	logic [7:0] new_b0;
	logic [7:0] new_b1;
	logic       new_d0;
	logic       new_len8;
	logic [5:0] new_col;
	logic [1:0] new_row;
	logic       new_wrapped;

	// Byte assembly from the job register
	logic       cur_data;
	logic [7:0] cur_value;
	logic [3:0] cur_nibble;
	logic       cur_enable;
	logic       cur_wait;

	assign idx_last = (idx_s1 == (len8_s1 ? 3'd7 : 3'd3));
	assign advance  = busy_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !busy_s1 || (advance && idx_last);
	assign in_fire  = in_valid && in_ready;

	// Cursor advance for a printed character or a new line
	always_comb begin
		is_newline = (char_code == lcdx_pkg::NEWLINE_CODE);
		if (is_newline) begin
			c_step = wrapped_q ? {1'b0, cursor_col_q} : {1'b0, columns_q};
		end else begin
			c_step = {1'b0, cursor_col_q} + 7'd1;
		end
		do_wrap   = (c_step >= {1'b0, columns_q});
		c_wrapped = do_wrap ? 7'd0 : c_step;
		r_step    = do_wrap ? ({1'b0, cursor_row_q} + 3'd1) : {1'b0, cursor_row_q};
		r_final   = (r_step >= lines_q) ? 3'd0 : r_step;
		if (do_wrap) begin
			wrapped_next = !is_newline;
		end else if (is_newline) begin
			wrapped_next = 1'b0;
		end else begin
			wrapped_next = wrapped_q;
		end
	end

	// Item decode: controller bytes and the cursor it leaves behind
	always_comb begin
		new_b0      = char_code;
		new_b1      = 8'd0;
		new_d0      = 1'b0;
		new_len8    = 1'b0;
		new_col     = cursor_col_q;
		new_row     = cursor_row_q;
		new_wrapped = wrapped_q;
		pos_col     = cursor_col_q;
		pos_row     = cursor_row_q;
		case (lcdx_pkg::mode_t'(mode))
			lcdx_pkg::MODE_PUT: begin
				new_col     = c_wrapped[5:0];
				new_row     = r_final[1:0];
				new_wrapped = wrapped_next;
				pos_col     = c_wrapped[5:0];
				pos_row     = r_final[1:0];
			end
			lcdx_pkg::MODE_MOVE: begin
				new_col = col;
				new_row = row;
				pos_col = col;
				pos_row = row;
			end
			lcdx_pkg::MODE_CLEAR: begin
				new_col = 6'd0;
				new_row = 2'd0;
			end
			default: begin
			end
		endcase

		// Set-DDRAM-address command for the new cursor position
		pos_sum = {3'd0, pos_col}
			+ (pos_row[0] ? {1'b0, lcdx_pkg::LINE1_OFFSET} : 9'd0)
			+ (pos_row[1] ? {3'd0, columns_q} : 9'd0);
		pos_cmd = pos_sum[7:0] | lcdx_pkg::CMD_DDRAM;

		case (lcdx_pkg::mode_t'(mode))
			lcdx_pkg::MODE_PUT: begin
				if (is_newline) begin
					new_b0 = pos_cmd;
				end else begin
					new_b0   = char_code;
					new_d0   = 1'b1;
					new_b1   = pos_cmd;
					new_len8 = 1'b1;
				end
			end
			lcdx_pkg::MODE_MOVE: begin
				new_b0 = pos_cmd;
			end
			lcdx_pkg::MODE_CLEAR: begin
				new_b0   = lcdx_pkg::CMD_CLEAR;
				new_b1   = lcdx_pkg::CMD_HOME;
				new_len8 = 1'b1;
			end
			default: begin
				new_b0 = char_code;
			end
		endcase
	end

	// Configuration registers, saturated where the geometry is limited
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q   <= ColsRst;
			lines_q     <= LinesRst;
			dev_addr_q  <= lcdx_pkg::DEV_ADDR_RESET;
			backlight_q <= lcdx_pkg::BACKLIGHT_RESET;
		end else if (cfg_we) begin
			case (lcdx_pkg::reg_index_t'(cfg_index))
				lcdx_pkg::REG_COLUMNS:
					columns_q <= (cfg_data[5:0] > MaxCols) ? MaxCols : cfg_data[5:0];
				lcdx_pkg::REG_LINES:
					lines_q <= (cfg_data[2:0] > MaxLines) ? MaxLines : cfg_data[2:0];
				lcdx_pkg::REG_DEV_ADDR:
					dev_addr_q <= cfg_data;
				default:
					backlight_q <= cfg_data[0];
			endcase
		end
	end

	// Cursor state moves on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= 6'd0;
			cursor_row_q <= 2'd0;
			wrapped_q    <= 1'b0;
		end else if (in_fire) begin
			cursor_col_q <= new_col;
			cursor_row_q <= new_row;
			wrapped_q    <= new_wrapped;
		end
	end

	// Job register control: loaded on a transfer in, stepped per byte out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			idx_s1  <= 3'd0;
		end else if (in_fire) begin
			busy_s1 <= 1'b1;
			idx_s1  <= 3'd0;
		end else if (advance) begin
			busy_s1 <= !idx_last;
			idx_s1  <= idx_s1 + 3'd1;
		end
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			b0_s1   <= new_b0;
			b1_s1   <= new_b1;
			d0_s1   <= new_d0;
			len8_s1 <= new_len8;
		end
	end

	// Expander byte for the current step: high nibble first, enable pulsed
	always_comb begin
		cur_data   = !idx_s1[2] && d0_s1;
		cur_value  = idx_s1[2] ? b1_s1 : b0_s1;
		cur_nibble = idx_s1[1] ? cur_value[3:0] : cur_value[7:4];
		cur_enable = !idx_s1[0];
		cur_wait   = (idx_s1[1:0] == 2'd3) && !cur_data
			&& (cur_value <= lcdx_pkg::SLOW_CMD_MAX);
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Output register payload: rw is always low
	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2 <= dev_addr_q;
			byte_s2 <= {cur_nibble, backlight_q, cur_enable, 1'b0, cur_data};
			wait_s2 <= cur_wait;
			last_s2 <= idx_last;
		end
	end

	assign out_valid     = out_valid_s2;
	assign bus_address   = addr_s2;
	assign expander_byte = byte_s2;
	assign long_wait     = wait_s2;
	assign last          = last_s2;

endmodule

FILE: rtl/lcdx_checker.sv
// ----------------------------------------------------------------------------
// lcdx_checker
// Port-level checks on the expander byte stream of the LCD writer, attached
// to the top level by the bind statement below.
// ----------------------------------------------------------------------------
`include "char_lcd_writer_over_expander_defines.svh"

module lcdx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] expander_byte,
	input logic       long_wait,
	input logic       last
);

	// A byte held back by the receiver keeps its value until transferred.
	`LCDX_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(expander_byte), "stalled expander byte changed")

	// The read/write line of the expander is never driven high.
	`LCDX_ASSERT_WHEN(a_rw_low, out_valid, !expander_byte[lcdx_pkg::EXP_RW_BIT], "rw bit set")

	// A long wait only follows a command byte, with enable already dropped.
	`LCDX_ASSERT_WHEN(a_wait_cmd, out_valid && long_wait, !expander_byte[lcdx_pkg::EXP_RS_BIT] && !expander_byte[lcdx_pkg::EXP_EN_BIT], "long wait on a data or enable byte")

	// Every enable pulse is closed by the same byte with enable cleared, next in line.
	`LCDX_ASSERT(a_enable_pair, out_valid && out_ready && expander_byte[lcdx_pkg::EXP_EN_BIT] |=> out_valid && !last && (expander_byte == ($past(expander_byte) & 8'hfb)) || out_valid && last && (expander_byte == ($past(expander_byte) & 8'hfb)), "enable pulse not followed by its falling byte")

	// The final byte of an item never leaves enable high.
	`LCDX_ASSERT_WHEN(a_last_enable, out_valid && last, !expander_byte[lcdx_pkg::EXP_EN_BIT], "last byte with enable set")

endmodule

bind char_lcd_writer_over_expander lcdx_checker u_lcdx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.expander_byte (expander_byte),
	.long_wait     (long_wait),
	.last          (last)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: character LCD writer over a port expander
// Sends put, move, clear and raw-command requests to the writer under several
// display geometries, predicts every expander byte with a cycle-free model of
// the cursor logic and compares each output transfer against it in order.
// ----------------------------------------------------------------------------
module tb_top;

	// Longest run of cycles without any transfer before the run is abandoned
	localparam int STALL_LIMIT = 1000;
	localparam logic [7:0] EN_MASK = 8'(1 << lcdx_pkg::EXP_EN_BIT);

	typedef struct {
		lcdx_pkg::mode_t kind;
		logic [7:0]      code;
		logic [5:0]      col;
		logic [1:0]      row;
	} lcd_request_t;

	typedef struct {
		logic [6:0] addr;
		logic [7:0] data;
		logic       slow;
		logic       fin;
	} lcd_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] mode = 2'd0;
	logic [7:0] char_code = 8'd0;
	logic [5:0] col = 6'd0;
	logic [1:0] row = 2'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] bus_address;
	logic [7:0] expander_byte;
	logic       long_wait;
	logic       last;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [6:0] cfg_data = 7'd0;

	// Requests waiting to be offered and expander bytes still owed by the block
	lcd_request_t lcd_requests[$];
	lcd_byte_t    expander_bytes_due[$];

	// Display settings and cursor as the block should hold them
	int         lcd_cols = lcdx_pkg::COLUMNS_RESET;
	int         lcd_lines = lcdx_pkg::LINES_RESET;
	logic [6:0] dev_addr = lcdx_pkg::DEV_ADDR_RESET;
	bit         bl_on = lcdx_pkg::BACKLIGHT_RESET;
	logic [5:0] cur_col = 6'd0;
	logic [1:0] cur_row = 2'd0;
	bit         wrap_pending = 1'b0;

	bit idle_on = 1'b0;
	bit long_hold_req = 1'b0;
	bit req_taken = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;
	int stalled_cycles = 0;
	int mismatches = 0;

	char_lcd_writer_over_expander uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.char_code    (char_code),
		.col          (col),
		.row          (row),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bus_address  (bus_address),
		.expander_byte(expander_byte),
		.long_wait    (long_wait),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One controller byte leaves as four expander bytes: high nibble with enable
	// pulsed, then the low nibble the same way.
	task automatic push_ctrl_byte(input logic [7:0] value, input bit is_data, input bit fin);
		lcd_byte_t  b;
		logic [7:0] base;
		logic [7:0] hi;
		logic [7:0] lo;
		base = (8'(bl_on) << lcdx_pkg::EXP_BL_BIT) | (8'(is_data) << lcdx_pkg::EXP_RS_BIT);
		hi = {value[7:4], 4'd0} | base;
		lo = {value[3:0], 4'd0} | base;
		b.addr = dev_addr;
		b.slow = 1'b0;
		b.fin = 1'b0;
		b.data = hi | EN_MASK;
		expander_bytes_due.push_back(b);
		b.data = hi;
		expander_bytes_due.push_back(b);
		b.data = lo | EN_MASK;
		expander_bytes_due.push_back(b);
		b.data = lo;
		b.slow = !is_data && (value <= lcdx_pkg::SLOW_CMD_MAX);
		b.fin = fin;
		expander_bytes_due.push_back(b);
	endtask

	// Set-DDRAM-address command for the current cursor position.
	task automatic push_position();
		int a;
		a = cur_col;
		if (cur_row[0])
			a += lcdx_pkg::LINE1_OFFSET;
		if (cur_row[1])
			a += lcd_cols;
		push_ctrl_byte(8'(a) | lcdx_pkg::CMD_DDRAM, 1'b0, 1'b1);
	endtask

	// Works out the bytes one request causes and moves the cursor on.
	task automatic encode_request(input lcd_request_t req);
		int c;
		int r;
		bit nl;
		case (req.kind)
			lcdx_pkg::MODE_PUT: begin
				c = cur_col;
				r = cur_row;
				nl = (req.code == lcdx_pkg::NEWLINE_CODE);
				if (nl) begin
					// A new line straight after a character wrap is swallowed
					if (wrap_pending)
						wrap_pending = 1'b0;
					else
						c = lcd_cols;
				end else begin
					push_ctrl_byte(req.code, 1'b1, 1'b0);
					c++;
				end
				if (c >= lcd_cols) begin
					c = 0;
					r++;
					wrap_pending = !nl;
				end
				if (r >= lcd_lines)
					r = 0;
				cur_col = 6'(c);
				cur_row = 2'(r);
				push_position();
			end
			lcdx_pkg::MODE_MOVE: begin
				cur_col = req.col;
				cur_row = req.row;
				push_position();
			end
			lcdx_pkg::MODE_CLEAR: begin
				push_ctrl_byte(lcdx_pkg::CMD_CLEAR, 1'b0, 1'b0);
				push_ctrl_byte(lcdx_pkg::CMD_HOME, 1'b0, 1'b1);
				cur_col = 6'd0;
				cur_row = 2'd0;
			end
			default: begin
				push_ctrl_byte(req.code, 1'b0, 1'b1);
			end
		endcase
	endtask

	task automatic queue_request(input lcdx_pkg::mode_t kind, input logic [7:0] code,
			input logic [5:0] c, input logic [1:0] r);
		lcd_request_t req;
		req.kind = kind;
		req.code = code;
		req.col = c;
		req.row = r;
		lcd_requests.push_back(req);
	endtask

	// Random request, weighted towards characters and towards moves near the
	// end of a line so that wraps and swallowed new lines come up often.
	function automatic lcd_request_t random_request();
		lcd_request_t req;
		int pick;
		pick = $urandom_range(0, 99);
		req.code = 8'($urandom);
		req.col = 6'($urandom);
		req.row = 2'($urandom);
		if (pick < 50) begin
			req.kind = lcdx_pkg::MODE_PUT;
			if ($urandom_range(0, 5) == 0)
				req.code = lcdx_pkg::NEWLINE_CODE;
		end else if (pick < 72) begin
			req.kind = lcdx_pkg::MODE_MOVE;
			if (pick < 64 && lcd_cols > 0)
				req.col = 6'(lcd_cols - 1 - $urandom_range(0, (lcd_cols - 1) % 4));
		end else if (pick < 80) begin
			req.kind = lcdx_pkg::MODE_CLEAR;
		end else begin
			req.kind = lcdx_pkg::MODE_RAW;
			if (pick < 90)
				req.code = 8'($urandom_range(0, 3));
		end
		return req;
	endfunction

	// Writes all four registers; called at a falling edge while the block is idle.
	task automatic program_display(input logic [6:0] cols, input logic [6:0] nlines,
			input logic [6:0] addr, input logic [6:0] bl);
		lcdx_pkg::reg_index_t idx;
		logic [6:0] val;
		for (int i = 0; i < 4; i++) begin
			idx = lcdx_pkg::reg_index_t'(i);
			case (idx)
				lcdx_pkg::REG_COLUMNS: begin
					val = cols;
					lcd_cols = (cols[5:0] > lcdx_pkg::MAX_COLUMNS_DEF) ?
						lcdx_pkg::MAX_COLUMNS_DEF : cols[5:0];
				end
				lcdx_pkg::REG_LINES: begin
					val = nlines;
					lcd_lines = (nlines[2:0] > lcdx_pkg::MAX_LINES_DEF) ?
						lcdx_pkg::MAX_LINES_DEF : nlines[2:0];
				end
				lcdx_pkg::REG_DEV_ADDR: begin
					val = addr;
					dev_addr = addr;
				end
				default: begin
					val = bl;
					bl_on = bl[0];
				end
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every request has gone in and every byte has come out.
	task automatic drain();
		do
			@(negedge clk);
		while (lcd_requests.size() != 0 || expander_bytes_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic feed_random(input int count);
		for (int i = 0; i < count; i++)
			lcd_requests.push_back(random_request());
	endtask

	// Request driver: a new payload is offered only once the previous transfer
	// has happened, with random bursts of idle cycles between requests.
	always @(negedge clk) begin : drive_requests
		bit holding;
		holding = in_valid && !req_taken;
		req_taken = 1'b0;
		if (!holding) begin
			if (src_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
				src_gap = $urandom_range(1, 16);
			if (src_gap > 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (lcd_requests.size() != 0) begin
				in_valid <= 1'b1;
				mode <= lcd_requests[0].kind;
				char_code <= lcd_requests[0].code;
				col <= lcd_requests[0].col;
				row <= lcd_requests[0].row;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output ready: random stall bursts, plus one long hold-off on request.
	always @(negedge clk) begin
		if (sink_gap == 0 && long_hold_req) begin
			long_hold_req = 1'b0;
			sink_gap = 80;
		end else if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0) begin
			sink_gap = $urandom_range(1, 16);
		end
		if (sink_gap > 0) begin
			sink_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Input transfer: the accepted request is turned into expected bytes.
	always @(posedge clk) begin : take_request
		lcd_request_t req;
		if (arst_n && in_valid && in_ready) begin
			req = lcd_requests.pop_front();
			encode_request(req);
			req_taken = 1'b1;
		end
	end

	// Output transfer: compare each byte with the oldest one still owed.
	always @(posedge clk) begin : check_bytes
		lcd_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expander_bytes_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected byte, expected none, got addr %h byte %h",
					$time, bus_address, expander_byte);
			end else begin
				want = expander_bytes_due.pop_front();
				if (bus_address !== want.addr) begin
					mismatches++;
					$display("%0t: bus_address expected %h, got %h",
						$time, want.addr, bus_address);
				end
				if (expander_byte !== want.data) begin
					mismatches++;
					$display("%0t: expander_byte expected %h, got %h",
						$time, want.data, expander_byte);
				end
				if (long_wait !== want.slow) begin
					mismatches++;
					$display("%0t: long_wait expected %b, got %b",
						$time, want.slow, long_wait);
				end
				if (last !== want.fin) begin
					mismatches++;
					$display("%0t: last expected %b, got %b", $time, want.fin, last);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles == STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		idle_on = 1'b1;

		// Directed requests under the reset geometry of 16 columns and 2 lines.
		queue_request(lcdx_pkg::MODE_PUT, 8'h41, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, 8'h00, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, 8'hff, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, lcdx_pkg::NEWLINE_CODE, 6'($urandom),
			2'($urandom));
		queue_request(lcdx_pkg::MODE_RAW, 8'h00, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_RAW, lcdx_pkg::SLOW_CMD_MAX, 6'($urandom),
			2'($urandom));
		queue_request(lcdx_pkg::MODE_RAW, 8'h04, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_RAW, 8'hff, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_RAW, lcdx_pkg::NEWLINE_CODE, 6'($urandom),
			2'($urandom));
		queue_request(lcdx_pkg::MODE_CLEAR, 8'($urandom), 6'($urandom), 2'($urandom));
		// Cursor placed beyond the display, then a character wraps it home
		queue_request(lcdx_pkg::MODE_MOVE, 8'($urandom), 6'd63, 2'd3);
		queue_request(lcdx_pkg::MODE_PUT, 8'h7a, 6'($urandom), 2'($urandom));
		// Character wrap followed by a swallowed new line and a real one
		queue_request(lcdx_pkg::MODE_MOVE, 8'($urandom), 6'd15, 2'd1);
		queue_request(lcdx_pkg::MODE_PUT, 8'h78, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, lcdx_pkg::NEWLINE_CODE, 6'($urandom),
			2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, lcdx_pkg::NEWLINE_CODE, 6'($urandom),
			2'($urandom));
		queue_request(lcdx_pkg::MODE_MOVE, 8'($urandom), 6'd0, 2'd0);
		queue_request(lcdx_pkg::MODE_MOVE, 8'($urandom), 6'd5, 2'd2);
		queue_request(lcdx_pkg::MODE_PUT, 8'h7e, 6'($urandom), 2'($urandom));
		// A clear leaves the wrap flag alone
		queue_request(lcdx_pkg::MODE_MOVE, 8'($urandom), 6'd15, 2'd0);
		queue_request(lcdx_pkg::MODE_PUT, 8'h71, 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_CLEAR, 8'($urandom), 6'($urandom), 2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, lcdx_pkg::NEWLINE_CODE, 6'($urandom),
			2'($urandom));
		queue_request(lcdx_pkg::MODE_PUT, 8'h80, 6'($urandom), 2'($urandom));
		drain();

		// Backlight off, top address; the output side holds off for a long spell.
		program_display(7'd16, 7'd2, 7'h7f, 7'd0);
		feed_random(45);
		long_hold_req = 1'b1;
		drain();

		// Oversized writes saturate to the largest geometry.
		program_display(7'd63, 7'd7, 7'h00, 7'd1);
		feed_random(45);
		drain();

		// Single cell display: every character wraps.
		program_display(7'd1, 7'd1, 7'($urandom), 7'd0);
		feed_random(30);
		drain();

		// No columns and no lines.
		program_display(7'd0, 7'd0, 7'($urandom), 7'd1);
		feed_random(20);
		drain();

		program_display(7'd8, 7'd3, 7'($urandom), 7'd1);
		feed_random(50);
		drain();

		// Final stretch at full rate on both sides.
		idle_on = 1'b0;
		program_display(7'd40, 7'd4, lcdx_pkg::DEV_ADDR_RESET, 7'd1);
		feed_random(60);
		drain();
		repeat (20) @(negedge clk);

		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
